>>> rtl/i2c_master_bit_sequencer_core_defines.svh
// Assertion macros used by the checker file.
`ifndef I2C_MASTER_BIT_SEQUENCER_CORE_DEFINES_SVH
`define I2C_MASTER_BIT_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define I2CMBS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("i2cmbs assertion failed");

// Next-cycle implication, sampled on aclk, off while in reset.
`define I2CMBS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("i2cmbs assertion failed");

`endif

>>> rtl/i2cmbs_pkg.sv
`timescale 1ns / 1ps
package i2cmbs_pkg;

    localparam int KIND_W = 3;
    localparam int BYTE_W = 8;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    localparam logic [BYTE_W-1:0] HALF_DELAY_RESET = 8'd5;

    // Input kind codes
    localparam logic [KIND_W-1:0] KIND_TICK  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_START = 3'd1;
    localparam logic [KIND_W-1:0] KIND_STOP  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WBIT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RBIT  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_WBYTE = 3'd5;
    localparam logic [KIND_W-1:0] KIND_RBYTE = 3'd6;

    // Running command, one-hot
    typedef enum logic [6:0] {
        OP_IDLE  = 7'b0000001,
        OP_START = 7'b0000010,
        OP_STOP  = 7'b0000100,
        OP_WBIT  = 7'b0001000,
        OP_RBIT  = 7'b0010000,
        OP_WBYTE = 7'b0100000,
        OP_RBYTE = 7'b1000000
    } op_t;

    function automatic op_t kind_to_op(input logic [KIND_W-1:0] kind);
        op_t op;
        case (kind)
            KIND_START: op = OP_START;
            KIND_STOP:  op = OP_STOP;
            KIND_WBIT:  op = OP_WBIT;
            KIND_RBIT:  op = OP_RBIT;
            KIND_WBYTE: op = OP_WBYTE;
            KIND_RBYTE: op = OP_RBYTE;
            default:    op = OP_IDLE;
        endcase
        return op;
    endfunction

endpackage

>>> rtl/i2c_master_bit_sequencer_core.sv
`timescale 1ns / 1ps
// I2C master bit sequencer. Every transfer on the s_ channel is one tick of the
// bus timebase; it may carry a command in s_tuser (start, stop, write bit, read
// bit, write byte with ACK sample, read byte MSB first). Every transfer in yields
// exactly one transfer out on the m_ channel with the SCL/SDA drive levels, busy,
// done, read data, ACK and a refused flag, all as they stand after that tick.
// Each pin change but the SCL fall closing a bit cell is followed by half_delay
// idle ticks (cfg_we/cfg_wdata, reset 5). A command that arrives while another one
// runs is dropped and flagged refused.
// Output: the result of a tick is in m_tdata in the cycle after its transfer.
// Throughput: one tick per cycle unless the output stalls; the whole step is one
// pass of combinational logic from the state registers into the output register.
// Stall: s_tready stays high while the output register is empty or being
// drained, so with m_tready low and a result waiting, input stops until the
// result is taken; nothing is dropped.
// Reset (aresetn low, synchronous): idle, both lines released, output empty,
// half_delay back to 5.
module i2c_master_bit_sequencer_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration: half_delay
    input  logic                              cfg_we,
    input  logic [i2cmbs_pkg::BYTE_W-1:0]     cfg_wdata,
    // input ticks
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [7:0] data_value, [8] sda_in, [15:9] zero
    input  logic [i2cmbs_pkg::S_TDATA_W-1:0]  s_tdata,
    // [2:0] kind
    input  logic [i2cmbs_pkg::KIND_W-1:0]     s_tuser,
    // results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [11:4] read_data,
    // [12] ack_bit, [13] refused, [15:14] zero
    output logic [i2cmbs_pkg::M_TDATA_W-1:0]  m_tdata
);
    import i2cmbs_pkg::*;

    // Configuration
    logic [BYTE_W-1:0] half_delay_reg;

    // Sequencer state
    op_t               op_reg,    op_next;
    logic [2:0]        phase_reg, phase_next;
    logic [BYTE_W-1:0] wait_reg,  wait_next;
    logic [3:0]        bit_reg,   bit_next;
    logic [BYTE_W-1:0] shift_reg, shift_next;
    logic              scl_reg,   scl_next;
    logic              sda_reg,   sda_next;

    // Output register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // Per-tick result
    logic              res_done;
    logic [BYTE_W-1:0] res_data;
    logic              res_ack;
    logic              res_refused;
    logic              reading;
    logic              sample;
    logic              fin;
    logic              accept;

    logic [KIND_W-1:0] in_kind;
    logic [BYTE_W-1:0] in_data;
    logic              in_sda;

    assign in_kind = s_tuser;
    assign in_data = s_tdata[BYTE_W-1:0];
    assign in_sda  = s_tdata[BYTE_W];

    // Output slot is free when empty or when its contents leave this cycle.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        op_next     = op_reg;
        phase_next  = phase_reg;
        wait_next   = wait_reg;
        bit_next    = bit_reg;
        shift_next  = shift_reg;
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        res_done    = 1'b0;
        res_data    = '0;
        res_ack     = 1'b0;
        res_refused = 1'b0;
        fin         = 1'b0;

        // Command launch, or refusal while busy
        if (in_kind inside {[KIND_START:KIND_RBYTE]}) begin
            if (op_reg != OP_IDLE) begin
                res_refused = 1'b1;
            end else begin
                op_next    = kind_to_op(in_kind);
                phase_next = 3'd0;
                wait_next  = '0;
                bit_next   = 4'd0;
                case (in_kind)
                    KIND_WBYTE: shift_next = in_data;
                    KIND_WBIT:  shift_next = {in_data[0], {(BYTE_W-1){1'b0}}};
                    default:    shift_next = '0;
                endcase
            end
        end

        // SDA released for read bits and for the ACK slot of a write byte
        reading = (op_next == OP_RBIT) || (op_next == OP_RBYTE) ||
                  ((op_next == OP_WBYTE) && (bit_next >= 4'd8));
        sample  = reading && in_sda;

        if (op_next != OP_IDLE) begin
            if (wait_next != '0) begin
                wait_next = wait_next - 8'd1;
            end else begin
                case (op_next)
                    OP_START: begin
                        case (phase_next)
                            3'd0: begin
                                sda_next = 1'b1;
                                scl_next = 1'b1;
                            end
                            3'd1: sda_next = 1'b0;
                            3'd2: scl_next = 1'b0;
                            default: fin = 1'b1;
                        endcase
                        if (!fin) begin
                            wait_next  = half_delay_reg;
                            phase_next = phase_next + 3'd1;
                        end
                    end
                    OP_STOP: begin
                        case (phase_next)
                            3'd0: sda_next = 1'b0;
                            3'd1: scl_next = 1'b1;
                            3'd2: sda_next = 1'b1;
                            default: fin = 1'b1;
                        endcase
                        if (!fin) begin
                            wait_next  = half_delay_reg;
                            phase_next = phase_next + 3'd1;
                        end
                    end
                    OP_WBIT, OP_RBIT, OP_WBYTE, OP_RBYTE: begin
                        if (phase_next == 3'd0) begin
                            sda_next   = reading ? 1'b1 : shift_next[BYTE_W-1];
                            wait_next  = half_delay_reg;
                            phase_next = 3'd1;
                        end else if (phase_next == 3'd1) begin
                            scl_next   = 1'b1;
                            wait_next  = half_delay_reg;
                            phase_next = 3'd2;
                        end else begin
                            // SCL falls; sample taken on this tick
                            scl_next   = 1'b0;
                            phase_next = 3'd0;
                            wait_next  = '0;
                            if (op_next == OP_WBIT) begin
                                fin = 1'b1;
                            end else if (op_next == OP_RBIT) begin
                                res_data = {{(BYTE_W-1){1'b0}}, sample};
                                fin      = 1'b1;
                            end else if (op_next == OP_WBYTE) begin
                                if (bit_next < 4'd8) begin
                                    shift_next = {shift_next[BYTE_W-2:0], 1'b0};
                                    bit_next   = bit_next + 4'd1;
                                end else begin
                                    res_ack = sample;
                                    fin     = 1'b1;
                                end
                            end else begin
                                shift_next = {shift_next[BYTE_W-2:0], sample};
                                bit_next   = bit_next + 4'd1;
                                if (bit_next >= 4'd8) begin
                                    res_data = shift_next;
                                    fin      = 1'b1;
                                end
                            end
                        end
                    end
                    default: fin = 1'b1;
                endcase
            end
        end

        if (fin) begin
            op_next    = OP_IDLE;
            phase_next = 3'd0;
            wait_next  = '0;
            res_done   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_delay_reg <= HALF_DELAY_RESET;
        end else if (cfg_we) begin
            half_delay_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg       <= OP_IDLE;
            phase_reg    <= 3'd0;
            wait_reg     <= '0;
            bit_reg      <= 4'd0;
            shift_reg    <= '0;
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            op_reg       <= op_next;
            phase_reg    <= phase_next;
            wait_reg     <= wait_next;
            bit_reg      <= bit_next;
            shift_reg    <= shift_next;
            scl_reg      <= scl_next;
            sda_reg      <= sda_next;
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {2'b00, res_refused, res_ack, res_data, res_done,
                            (op_next != OP_IDLE), sda_next, scl_next};
        end
    end

endmodule

>>> rtl/i2cmbs_checker.sv
`timescale 1ns / 1ps
`include "i2c_master_bit_sequencer_core_defines.svh"
module i2cmbs_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [i2cmbs_pkg::M_TDATA_W-1:0]  m_tdata
);
    import i2cmbs_pkg::*;

    // a completed command leaves the sequencer idle
    `I2CMBS_ASSERT_IMP(a_done_not_busy, m_tvalid && m_tdata[3], !m_tdata[2])
    // read data and ACK only show on the completing tick
    `I2CMBS_ASSERT_IMP(a_data_on_done, m_tvalid && ((m_tdata[11:4] != 8'd0) || m_tdata[12]), m_tdata[3])
    // a draining output never blocks input
    `I2CMBS_ASSERT_IMP(a_ready_when_drained, m_tready, s_tready)
    // stalled result holds
    `I2CMBS_ASSERT_NXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind i2c_master_bit_sequencer_core i2cmbs_checker u_i2cmbs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/i2c_master_bit_sequencer_core_tb.sv
`timescale 1ns / 1ps
module i2c_master_bit_sequencer_core_tb;
    import i2cmbs_pkg::*;

    // Kind 7 is unused by the block: an ordinary tick, never refused.
    localparam logic [KIND_W-1:0] KIND_SPARE = 3'd7;

    // Generous ceiling, far above the slowest legal run with every gap and stall at its longest.
    localparam longint CYCLE_LIMIT = 64'd4_000_000;
    // Drain allowance after the last result: the output register, plus margin.
    localparam int DRAIN_CYCLES = 4;

    // Expected bus state after one tick, laid out exactly as m_tdata.
    typedef struct packed {
        logic [1:0]        spare;
        logic              refused;
        logic              ack;
        logic [BYTE_W-1:0] rd_data;
        logic              done;
        logic              busy;
        logic              sda;
        logic              scl;
    } bus_line_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [BYTE_W-1:0]    cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [KIND_W-1:0]    s_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Shadow of the sequencer state, advanced once per accepted tick.
    op_t               bus_op;
    logic [2:0]        bus_phase;
    logic [7:0]        hold_cnt;
    logic [3:0]        bit_cnt;
    logic [7:0]        shifter;
    logic              scl_lvl;
    logic              sda_lvl;
    logic [7:0]        pred_half_delay;

    bus_line_t         lines_due[$];
    int                mismatches = 0;
    longint            cycles = 0;
    int                items_sent = 0;
    int                cmds_done = 0;
    int                stall_left = 0;

    // Behaviour of the far end: byte it returns on reads, and its acknowledge.
    logic [7:0]        slave_byte;
    logic              slave_ack;
    bit                noise_on;
    // Set to run a stretch with no gaps on either side.
    bit                pace_free;

    i2c_master_bit_sequencer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Run guard.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("i2c_master_bit_sequencer_core test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void reset_predictor();
        bus_op          = OP_IDLE;
        bus_phase       = '0;
        hold_cnt        = '0;
        bit_cnt         = '0;
        shifter         = '0;
        scl_lvl         = 1'b1;
        sda_lvl         = 1'b1;
        pred_half_delay = HALF_DELAY_RESET;
    endfunction

    // One pin change, then the half-period hold before the next step.
    function automatic void pin_step(bit set_sda, logic sda_v, bit set_scl, logic scl_v);
        if (set_sda)
            sda_lvl = sda_v;
        if (set_scl)
            scl_lvl = scl_v;
        hold_cnt  = pred_half_delay;
        bus_phase = bus_phase + 3'd1;
    endfunction

    function automatic void wrap_up();
        bus_op    = OP_IDLE;
        bus_phase = '0;
        hold_cnt  = '0;
    endfunction

    function automatic bus_line_t predict_tick(logic [KIND_W-1:0] kind, logic [7:0] dval,
                                               logic sda_in);
        bus_line_t r;
        logic      reading;
        logic      smp;
        r = '0;
        // Command accept or refusal; kind 7 is just a tick.
        if (kind >= KIND_START && kind <= KIND_RBYTE) begin
            if (bus_op != OP_IDLE) begin
                r.refused = 1'b1;
            end else begin
                case (kind)
                    KIND_START: bus_op = OP_START;
                    KIND_STOP:  bus_op = OP_STOP;
                    KIND_WBIT:  bus_op = OP_WBIT;
                    KIND_RBIT:  bus_op = OP_RBIT;
                    KIND_WBYTE: bus_op = OP_WBYTE;
                    default:    bus_op = OP_RBYTE;
                endcase
                bus_phase = '0;
                hold_cnt  = '0;
                bit_cnt   = '0;
                if (kind == KIND_WBYTE)
                    shifter = dval;
                else if (kind == KIND_WBIT)
                    shifter = {dval[0], 7'b0};
                else
                    shifter = '0;
            end
        end
        if (bus_op != OP_IDLE) begin
            if (hold_cnt != 8'd0) begin
                hold_cnt = hold_cnt - 8'd1;
            end else if (bus_op == OP_START) begin
                // both high, SDA falls, SCL falls, closing hold
                case (bus_phase)
                    3'd0:    pin_step(1'b1, 1'b1, 1'b1, 1'b1);
                    3'd1:    pin_step(1'b1, 1'b0, 1'b0, 1'b0);
                    3'd2:    pin_step(1'b0, 1'b0, 1'b1, 1'b0);
                    default: begin
                        wrap_up();
                        r.done = 1'b1;
                    end
                endcase
            end else if (bus_op == OP_STOP) begin
                // SDA low, SCL rises, SDA rises, closing hold
                case (bus_phase)
                    3'd0:    pin_step(1'b1, 1'b0, 1'b0, 1'b0);
                    3'd1:    pin_step(1'b0, 1'b0, 1'b1, 1'b1);
                    3'd2:    pin_step(1'b1, 1'b1, 1'b0, 1'b0);
                    default: begin
                        wrap_up();
                        r.done = 1'b1;
                    end
                endcase
            end else begin
                // Bit cell: ninth cell of a byte write is the ACK read.
                reading = (bus_op == OP_RBIT) || (bus_op == OP_RBYTE) ||
                          (bus_op == OP_WBYTE && bit_cnt >= 4'd8);
                if (bus_phase == 3'd0) begin
                    pin_step(1'b1, reading ? 1'b1 : shifter[7], 1'b0, 1'b0);
                end else if (bus_phase == 3'd1) begin
                    pin_step(1'b0, 1'b0, 1'b1, 1'b1);
                end else begin
                    smp       = reading ? sda_in : 1'b0;
                    scl_lvl   = 1'b0;
                    bus_phase = '0;
                    hold_cnt  = '0;
                    case (bus_op)
                        OP_WBIT: begin
                            wrap_up();
                            r.done = 1'b1;
                        end
                        OP_RBIT: begin
                            r.rd_data = {7'b0, smp};
                            wrap_up();
                            r.done = 1'b1;
                        end
                        OP_WBYTE: begin
                            if (bit_cnt < 4'd8) begin
                                shifter = shifter << 1;
                                bit_cnt = bit_cnt + 4'd1;
                            end else begin
                                r.ack = smp;
                                wrap_up();
                                r.done = 1'b1;
                            end
                        end
                        default: begin
                            shifter = {shifter[6:0], smp};
                            bit_cnt = bit_cnt + 4'd1;
                            if (bit_cnt >= 4'd8) begin
                                r.rd_data = shifter;
                                wrap_up();
                                r.done = 1'b1;
                            end
                        end
                    endcase
                end
            end
        end
        r.scl  = scl_lvl;
        r.sda  = sda_lvl;
        r.busy = (bus_op != OP_IDLE);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Predict on every input transfer, check every output transfer.
    // Predict first so a same-cycle result would still find its entry.
    // ------------------------------------------------------------------
    task automatic check_field(input string label, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : predict_and_check
        bus_line_t want;
        bus_line_t got;
        if (aresetn) begin
            if (cfg_we)
                pred_half_delay = cfg_wdata;
            if (s_tvalid && s_tready) begin
                want = predict_tick(s_tuser, s_tdata[7:0], s_tdata[8]);
                lines_due.push_back(want);
                items_sent++;
                if (want.done)
                    cmds_done++;
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (lines_due.size() == 0) begin
                    $display("%0t: unexpected result transfer, expected none, actual %04h",
                             $time, m_tdata);
                    mismatches++;
                end else begin
                    want = lines_due.pop_front();
                    check_field("scl_out",   BYTE_W'(want.scl),     BYTE_W'(got.scl));
                    check_field("sda_out",   BYTE_W'(want.sda),     BYTE_W'(got.sda));
                    check_field("busy",      BYTE_W'(want.busy),    BYTE_W'(got.busy));
                    check_field("done",      BYTE_W'(want.done),    BYTE_W'(got.done));
                    check_field("read_data", want.rd_data,          got.rd_data);
                    check_field("ack_bit",   BYTE_W'(want.ack),     BYTE_W'(got.ack));
                    check_field("refused",   BYTE_W'(want.refused), BYTE_W'(got.refused));
                    check_field("spare",     BYTE_W'(want.spare),   BYTE_W'(got.spare));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Pacing: mostly back to back, some short gaps, the odd long one.
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (pace_free)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    // Result side back-pressure, drawn at the falling edge.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            if (!pace_free && $urandom_range(0, 7) == 0)
                stall_left = pick_gap();
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    // Small delays mostly, so most commands finish quickly.
    function automatic logic [7:0] pick_delay();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 8'(r);
        return 8'($urandom_range(0, 12));
    endfunction

    // SDA as the far end would drive it for the cell now running.
    function automatic logic line_level();
        logic b;
        b = 1'($urandom_range(0, 1));
        case (bus_op)
            OP_RBYTE: b = slave_byte[7 - bit_cnt];
            OP_RBIT:  b = slave_byte[0];
            OP_WBYTE: if (bit_cnt >= 4'd8) b = slave_ack;
            default: ;
        endcase
        if (noise_on && $urandom_range(0, 15) == 0)
            b = ~b;
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    // One transfer on the s_ side. Leaves tvalid high on return, so the
    // caller either sends again at once or lowers it before waiting.
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [7:0] dval,
                             input logic sda);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser  <= kind;
        s_tdata  <= {{(S_TDATA_W - 9){1'b0}}, sda, dval};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Plain ticks until the command finishes; with meddle set, the odd
    // command is thrown in while busy and must be refused.
    task automatic tick_until_idle(input bit meddle);
        logic [KIND_W-1:0] k;
        while (bus_op != OP_IDLE) begin
            k = KIND_TICK;
            if (meddle && $urandom_range(0, 31) == 0)
                k = KIND_W'($urandom_range(1, 7));
            send_item(k, rand_byte(), line_level());
        end
    endtask

    task automatic run_command(input logic [KIND_W-1:0] kind, input logic [7:0] dval,
                               input bit meddle);
        send_item(kind, dval, line_level());
        tick_until_idle(meddle);
    endtask

    // Sender stops until every result is in, plus the output latency.
    task automatic wait_results();
        s_tvalid <= 1'b0;
        while (lines_due.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic set_half_delay(input logic [7:0] value);
        wait_results();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // Out of reset the hold is 5 ticks.
    task automatic test_reset_values();
        send_item(KIND_TICK, 8'h00, 1'b0);
        send_item(KIND_SPARE, 8'hFF, 1'b1);
        run_command(KIND_START, 8'h00, 1'b0);
        run_command(KIND_STOP, 8'hFF, 1'b0);
    endtask

    // Only bit 0 of the data matters for a bit write.
    task automatic test_single_bits();
        set_half_delay(8'd1);
        run_command(KIND_WBIT, 8'hFE, 1'b0);
        run_command(KIND_WBIT, 8'h01, 1'b0);
        slave_byte = 8'h00;
        run_command(KIND_RBIT, 8'hFF, 1'b0);
        slave_byte = 8'hFF;
        run_command(KIND_RBIT, 8'h00, 1'b0);
    endtask

    task automatic test_byte_extremes();
        set_half_delay(8'd2);
        slave_ack = 1'b0;
        run_command(KIND_WBYTE, 8'h00, 1'b0);
        slave_ack = 1'b1;
        run_command(KIND_WBYTE, 8'hFF, 1'b0);
        slave_byte = 8'hFF;
        run_command(KIND_RBYTE, 8'h00, 1'b0);
        slave_byte = 8'h00;
        run_command(KIND_RBYTE, 8'hFF, 1'b0);
        slave_ack = 1'b0;
        run_command(KIND_WBYTE, 8'hA5, 1'b0);
        slave_byte = 8'h5A;
        run_command(KIND_RBYTE, 8'h00, 1'b0);
    endtask

    // No hold: one step per tick.
    task automatic test_zero_delay();
        set_half_delay(8'd0);
        run_command(KIND_START, 8'h00, 1'b0);
        slave_ack = 1'b1;
        run_command(KIND_WBYTE, 8'h3C, 1'b0);
        slave_byte = 8'hC3;
        run_command(KIND_RBYTE, 8'h00, 1'b0);
        run_command(KIND_STOP, 8'h00, 1'b0);
    endtask

    // Commands while busy, including on the tick the running one ends.
    task automatic test_busy_refusal();
        int n;
        // zero hold: a bit write ends on its third tick
        send_item(KIND_WBIT, 8'h01, 1'b0);
        send_item(KIND_SPARE, 8'h00, 1'b0);
        send_item(KIND_RBIT, 8'h00, 1'b1);
        send_item(KIND_RBIT, 8'h00, 1'b1);
        tick_until_idle(1'b0);
        // every command kind thrown in turn while a START runs
        set_half_delay(8'd3);
        send_item(KIND_START, 8'h00, 1'b1);
        n = 0;
        while (bus_op != OP_IDLE) begin
            send_item(KIND_W'(KIND_START + n % 6), rand_byte(), 1'b1);
            n++;
        end
    endtask

    // Longest hold on a single read bit, run without gaps to keep it short.
    task automatic test_max_delay();
        pace_free = 1'b1;
        set_half_delay(8'd255);
        slave_byte = rand_byte();
        run_command(KIND_RBIT, 8'h00, 1'b0);
        set_half_delay(8'd3);
        pace_free = 1'b0;
    endtask

    // Mostly well-formed transactions, some cut short, some noise,
    // with the hold changed between them.
    task automatic test_random_traffic();
        int                first_item;
        int                pick;
        int                n;
        logic [KIND_W-1:0] k;
        first_item = items_sent;
        while (items_sent - first_item < 700) begin
            pick      = $urandom_range(0, 99);
            pace_free = ($urandom_range(0, 4) == 0);
            noise_on  = ($urandom_range(0, 3) == 0);
            if (pick < 10) begin
                set_half_delay(pick_delay());
            end else if (pick < 22) begin
                n = $urandom_range(1, 6);
                repeat (n) send_item(KIND_W'($urandom_range(0, 7)), rand_byte(),
                                     1'($urandom_range(0, 1)));
                tick_until_idle(1'b1);
            end else begin
                run_command(KIND_START, rand_byte(), 1'b1);
                slave_ack = ($urandom_range(0, 3) == 0);
                run_command(KIND_WBYTE, rand_byte(), 1'b1);
                n = $urandom_range(0, 3);
                repeat (n) begin
                    case ($urandom_range(0, 4))
                        0:       k = KIND_WBIT;
                        1:       k = KIND_RBIT;
                        2:       k = KIND_WBYTE;
                        3:       k = KIND_RBYTE;
                        default: k = KIND_START;   // repeated start
                    endcase
                    slave_byte = rand_byte();
                    slave_ack  = ($urandom_range(0, 3) == 0);
                    run_command(k, rand_byte(), 1'b1);
                end
                // now and then the STOP is left off
                if ($urandom_range(0, 9) != 0)
                    run_command(KIND_STOP, rand_byte(), 1'b1);
            end
        end
        pace_free = 1'b0;
        noise_on  = 1'b0;
    endtask

    initial begin
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = KIND_TICK;
        slave_byte = '0;
        slave_ack  = 1'b0;
        noise_on   = 1'b0;
        pace_free  = 1'b0;
        reset_predictor();
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_values();
        test_single_bits();
        test_byte_extremes();
        test_zero_delay();
        test_busy_refusal();
        test_max_delay();
        test_random_traffic();

        wait_results();
        if (mismatches == 0)
            $display("i2c_master_bit_sequencer_core test passed");
        else
            $display("i2c_master_bit_sequencer_core test failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/i2cmbs_pkg.sv
rtl/i2c_master_bit_sequencer_core.sv
rtl/i2cmbs_checker.sv
tb/i2c_master_bit_sequencer_core_tb.sv
